[sv/polynomial_false_position_root_assert.svh]
// assertion macros used by the root finder top level
`ifndef POLYNOMIAL_FALSE_POSITION_ROOT_ASSERT_SVH
`define POLYNOMIAL_FALSE_POSITION_ROOT_ASSERT_SVH

// consequence must hold in the same cycle as the condition
`define PFPR_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("root finder check failed");

// consequence must hold in the cycle after the condition
`define PFPR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("root finder check failed");

`endif

[sv/pfpr_pkg.sv]
// shared constants, types and helpers of the false position root finder
package pfpr_pkg;

    localparam int MAX_ITERATIONS = 100;
    localparam int MAX_COEFFS     = 7;
    localparam int ITER_W         = 7;
    localparam int STEP_W         = 6;
    localparam int DIV_STEPS      = 63;
    localparam int MUL_STEPS      = 32;

    // eps is 7 lsb of q16.16
    localparam logic signed [63:0] EPS_WIDE     = 64'sd7;
    localparam logic signed [63:0] NEG_EPS_WIDE = -64'sd7;
    localparam logic signed [31:0] EPS_X        = 32'sd7;
    localparam logic signed [31:0] NEG_EPS_X    = -32'sd7;
    localparam logic [32:0]        EPS_SPAN     = 33'd7;

    localparam logic [63:0]        SAT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        H_LIMIT  = 64'h0000_8000_0000_0000;
    localparam logic signed [64:0] SUM_HI   = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_LO   = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    // result codes
    localparam logic [1:0] OUT_CONVERGED  = 2'd0;
    localparam logic [1:0] OUT_LIMIT      = 2'd1;
    localparam logic [1:0] OUT_ENDPOINT   = 2'd2;
    localparam logic [1:0] OUT_NO_BRACKET = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_COUNT = 3'd0;

    typedef logic signed [31:0] coef_array_t [MAX_COEFFS];

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } arith_op_t;

    // magnitude of a 64-bit signed value
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    // magnitude of a 32-bit signed value
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

[sv/polynomial_false_position_root.sv]
// top level: configuration registers and false position sequencer
// Finds a root of the configured polynomial (up to seven signed Q16.16
// coefficients) between left_end and right_end. A transfer is taken when start
// is high and busy is low; busy then stays high until the single result comes.
// The result is shown for exactly one cycle with done high and cannot be held
// off. Each polynomial evaluation runs magnitude, high multiply, low multiply,
// scale and add steps per coefficient, then a finish step, on one shared 32x32
// multiplier. Each chord step runs a test, a normalization of both magnitudes,
// the bit-serial divide and its multiply, a fix of the intercept and one
// evaluation, for up to 100 chords per item. Configuration must be written
// only while busy is low; the block itself does not enforce it.
`include "polynomial_false_position_root_assert.svh"

module polynomial_false_position_root
    import pfpr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  left_end,
    input  logic signed [31:0]  right_end,
    output logic                done,
    output logic signed [31:0]  root,
    output logic [1:0]          outcome,
    output logic [ITER_W-1:0]   iteration_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVA,
        S_EVB,
        S_CHECK,
        S_TEST,
        S_NORM,
        S_DIV,
        S_MUL,
        S_XFIX,
        S_EVX
    } state_t;

    state_t              state_reg, state_next;
    logic signed [31:0]  a_reg, a_next;
    logic signed [31:0]  b_reg, b_next;
    logic signed [63:0]  fa_reg, fa_next;
    logic signed [63:0]  fb_reg, fb_next;
    logic signed [31:0]  x_reg, x_next;
    logic [63:0]         ma_reg, ma_next;
    logic [63:0]         mb_reg, mb_next;
    logic [ITER_W-1:0]   count_reg, count_next;
    logic signed [31:0]  root_reg, root_next;
    logic [1:0]          outcome_reg, outcome_next;
    logic                done_reg, done_next;
    logic [2:0]          coefficient_count_reg;
    coef_array_t         coef_reg;

    logic                eval_start;
    logic signed [31:0]  eval_x;
    logic                eval_done;
    logic signed [63:0]  eval_value;
    logic                unit_start;
    arith_op_t           unit_op;
    logic [31:0]         unit_a;
    logic [31:0]         unit_b;
    logic                unit_done;
    logic [63:0]         unit_result;

    logic signed [32:0]  span;
    logic [32:0]         span_mag;
    logic [64:0]         mag_sum;
    logic [31:0]         step_d;
    logic signed [32:0]  x_chord;
    logic signed [31:0]  x_fixed;
    logic                fa_pos, fa_neg, fb_pos, fb_neg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefficient_count_reg <= 3'd1;
            for (int i = 0; i < MAX_COEFFS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_COUNT)
                coefficient_count_reg <= cfg_data[2:0];
            else
                coef_reg[cfg_index - 3'd1] <= cfg_data;
        end
    end

    // polynomial evaluator
    pfpr_horner u_horner (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (eval_start),
        .x                 (eval_x),
        .coefficient_count (coefficient_count_reg),
        .coefs             (coef_reg),
        .done              (eval_done),
        .value             (eval_value)
    );

    // divide and multiply unit
    pfpr_divmul u_divmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .op     (unit_op),
        .opa    (unit_a),
        .opb    (unit_b),
        .done   (unit_done),
        .result (unit_result)
    );

    // interval arithmetic
    assign span     = {b_reg[31], b_reg} - {a_reg[31], a_reg};
    assign span_mag = span[32] ? 33'(-span) : 33'(span);
    assign mag_sum  = {1'b0, ma_reg} + {1'b0, mb_reg};
    assign step_d   = unit_result[62:31];
    assign x_chord  = span[32] ? {a_reg[31], a_reg} - {1'b0, step_d}
                               : {a_reg[31], a_reg} + {1'b0, step_d};
    assign x_fixed  = ((x_reg > NEG_EPS_X) && (x_reg < EPS_X)) ? '0 : x_reg;

    assign fa_neg = fa_reg[63];
    assign fb_neg = fb_reg[63];
    assign fa_pos = !fa_reg[63] && (fa_reg != '0);
    assign fb_pos = !fb_reg[63] && (fb_reg != '0);

    // unit control
    always_comb
    begin
        eval_start = 1'b0;
        eval_x     = x_fixed;
        unit_start = 1'b0;
        unit_op    = OP_DIV;
        unit_a     = ma_reg[31:0];
        unit_b     = mag_sum[31:0];
        case (state_reg)
            S_IDLE:
            begin
                eval_start = start;
                eval_x     = left_end;
            end
            S_EVA:
            begin
                eval_start = eval_done;
                eval_x     = b_reg;
            end
            S_NORM:
            begin
                unit_start = (mag_sum[64:32] == '0) && (mag_sum != '0);
            end
            S_DIV:
            begin
                unit_start = unit_done;
                unit_op    = OP_MUL;
                unit_a     = span_mag[31:0];
                unit_b     = unit_result[31:0];
            end
            S_XFIX:
            begin
                eval_start = 1'b1;
            end
            default:
            begin
                eval_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        x_next       = x_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        count_next   = count_reg;
        root_next    = root_reg;
        outcome_next = outcome_reg;
        done_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = left_end;
                    b_next     = right_end;
                    state_next = S_EVA;
                end
            end
            S_EVA:
            begin
                if (eval_done)
                begin
                    fa_next    = eval_value;
                    state_next = S_EVB;
                end
            end
            S_EVB:
            begin
                if (eval_done)
                begin
                    fb_next    = eval_value;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                count_next = '0;
                x_next     = a_reg;
                if ((fa_pos && fb_neg) || (fa_neg && fb_pos))
                    state_next = S_TEST;
                else
                begin
                    if (fa_reg == '0)
                    begin
                        root_next    = a_reg;
                        outcome_next = OUT_ENDPOINT;
                    end
                    else if (fb_reg == '0)
                    begin
                        root_next    = b_reg;
                        outcome_next = OUT_ENDPOINT;
                    end
                    else
                    begin
                        root_next    = '0;
                        outcome_next = OUT_NO_BRACKET;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TEST:
            begin
                if ((span_mag >= EPS_SPAN) && (count_reg < ITER_W'(MAX_ITERATIONS)))
                begin
                    ma_next    = mag64(fa_reg);
                    mb_next    = mag64(fb_reg);
                    state_next = S_NORM;
                end
                else
                begin
                    root_next    = x_reg;
                    outcome_next = OUT_LIMIT;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_NORM:
            begin
                // halve both magnitudes until their sum fits 32 bits
                if (mag_sum[64:32] != '0)
                begin
                    ma_next = {1'b0, ma_reg[63:1]};
                    mb_next = {1'b0, mb_reg[63:1]};
                end
                else if (mag_sum == '0)
                begin
                    x_next     = a_reg;
                    state_next = S_XFIX;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (unit_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (unit_done)
                begin
                    x_next     = x_chord[31:0];
                    state_next = S_XFIX;
                end
            end
            S_XFIX:
            begin
                x_next     = x_fixed;
                state_next = S_EVX;
            end
            S_EVX:
            begin
                if (eval_done)
                begin
                    if (eval_value == '0)
                    begin
                        root_next    = x_reg;
                        outcome_next = OUT_CONVERGED;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        if (fa_reg[63] != eval_value[63])
                        begin
                            b_next  = x_reg;
                            fb_next = eval_value;
                        end
                        else
                        begin
                            a_next  = x_reg;
                            fa_next = eval_value;
                        end
                        count_next = count_reg + ITER_W'(1);
                        state_next = S_TEST;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        x_reg       <= x_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        count_reg   <= count_next;
        root_reg    <= root_next;
        outcome_reg <= outcome_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign root            = root_reg;
    assign outcome         = outcome_reg;
    assign iteration_count = count_reg;

    // checks
    `PFPR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `PFPR_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `PFPR_ASSERT_SAME(a_count_limit, clk, rst_n, done,
        iteration_count <= ITER_W'(MAX_ITERATIONS))
    `PFPR_ASSERT_SAME(a_no_bracket, clk, rst_n, done && (outcome == OUT_NO_BRACKET),
        (root == '0) && (iteration_count == '0))

endmodule

[sv/pfpr_horner.sv]
// polynomial evaluator: horner scheme on one shared 32x32 multiplier
module pfpr_horner
    import pfpr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  x,
    input  logic [2:0]          coefficient_count,
    input  coef_array_t         coefs,
    output logic                done,
    output logic signed [63:0]  value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_MUL_HI,
        S_MUL_LO,
        S_SCALE,
        S_ADD,
        S_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        x_mag_reg, x_mag_next;
    logic               x_neg_reg, x_neg_next;
    logic [2:0]         idx_reg, idx_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]        ua_reg, ua_next;
    logic               neg_reg, neg_next;
    logic [63:0]        h_reg, h_next;
    logic [63:0]        l_reg, l_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               done_reg, done_next;
    logic signed [63:0] value_reg, value_next;

    logic [31:0]        mul_a;
    logic [63:0]        mul_p;
    logic [63:0]        q_raw;
    logic [63:0]        q_sat;
    logic signed [64:0] sum_wide;

    // shared multiplier, high or low half of the accumulator magnitude
    assign mul_a = (state_reg == S_MUL_HI) ? ua_reg[63:32] : ua_reg[31:0];
    assign mul_p = 64'(mul_a) * 64'(x_mag_reg);

    // rescale by 2^-16 with saturation
    assign q_raw = {h_reg[47:0], 16'h0000} + {16'h0000, l_reg[63:16]};
    assign q_sat = ((h_reg >= H_LIMIT) || q_raw[63]) ? SAT_MAX : q_raw;

    // add coefficient in 65 bits
    assign sum_wide = {prod_reg[63], prod_reg} + 65'(coefs[idx_reg]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        x_mag_next = x_mag_reg;
        x_neg_next = x_neg_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        ua_next    = ua_reg;
        neg_next   = neg_reg;
        h_next     = h_reg;
        l_next     = l_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (coefficient_count == 3'd0)
                    begin
                        value_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        acc_next   = '0;
                        idx_next   = '0;
                        x_mag_next = mag32(x);
                        x_neg_next = x[31];
                        state_next = S_MAG;
                    end
                end
            end
            S_MAG:
            begin
                ua_next    = mag64(acc_reg);
                neg_next   = acc_reg[63] ^ x_neg_reg;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                h_next     = mul_p;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                l_next     = mul_p;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                prod_next  = neg_reg ? -$signed(q_sat) : $signed(q_sat);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (sum_wide > SUM_HI)
                    acc_next = $signed(SAT_MAX);
                else if (sum_wide < SUM_LO)
                    acc_next = -$signed(SAT_MAX);
                else
                    acc_next = sum_wide[63:0];
                if (idx_reg == coefficient_count - 3'd1)
                    state_next = S_FIN;
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = S_MAG;
                end
            end
            S_FIN:
            begin
                if ((acc_reg > NEG_EPS_WIDE) && (acc_reg < EPS_WIDE))
                    value_next = '0;
                else
                    value_next = acc_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_mag_reg <= x_mag_next;
        x_neg_reg <= x_neg_next;
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        ua_reg    <= ua_next;
        neg_reg   <= neg_next;
        h_reg     <= h_next;
        l_reg     <= l_next;
        prod_reg  <= prod_next;
        value_reg <= value_next;
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

[sv/pfpr_divmul.sv]
// bit-serial unit: restoring divide of opa*2^31 by opb, or shift-add multiply
module pfpr_divmul
    import pfpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  arith_op_t   op,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [63:0] result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    arith_op_t         op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [32:0]       rem_reg, rem_next;
    logic [62:0]       p_reg, p_next;
    logic [31:0]       d_reg, d_next;

    logic [32:0]       rem_sh;
    logic              ge;
    logic [32:0]       add_sum;

    // divide step
    assign rem_sh = {rem_reg[31:0], p_reg[62]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    // multiply step
    assign add_sum = {1'b0, rem_reg[31:0]} + (p_reg[0] ? {1'b0, d_reg} : 33'd0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        p_next    = p_reg;
        d_next    = d_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                op_next   = op;
                rem_next  = '0;
                case (op)
                    OP_DIV:
                    begin
                        p_next    = {opa, 31'd0};
                        d_next    = opb;
                        step_next = STEP_W'(DIV_STEPS - 1);
                    end
                    OP_MUL:
                    begin
                        p_next    = {31'd0, opb};
                        d_next    = opa;
                        step_next = STEP_W'(MUL_STEPS - 1);
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            case (op_reg)
                OP_DIV:
                begin
                    rem_next = ge ? rem_sh - {1'b0, d_reg} : rem_sh;
                    p_next   = {p_reg[61:0], ge};
                end
                OP_MUL:
                begin
                    rem_next = {1'b0, add_sum[32:1]};
                    p_next   = {p_reg[62:32], add_sum[0], p_reg[31:1]};
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        p_reg    <= p_next;
        d_reg    <= d_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_DIV) ? {32'd0, p_reg[31:0]} : {rem_reg[31:0], p_reg[31:0]};

endmodule

[tb/tb_top.sv]
// testbench for the false position polynomial root finder
module tb_top;
    import pfpr_pkg::*;

    localparam logic [2:0] CFG_COEF0  = 3'd1;
    localparam int         IDLE_LIMIT = 60000;

    typedef struct {
        logic signed [31:0] root;
        logic [1:0]         outcome;
        logic [ITER_W-1:0]  iters;
    } root_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;
    logic                start;
    logic                busy;
    logic signed [31:0]  left_end;
    logic signed [31:0]  right_end;
    logic                done;
    logic signed [31:0]  root;
    logic [1:0]          outcome;
    logic [ITER_W-1:0]   iteration_count;

    // copy of the configuration held by the predictor
    logic [2:0]          poly_len;
    logic signed [31:0]  poly_coef [MAX_COEFFS];

    root_result_t        pending_roots [$];
    int                  mismatches;
    int                  idle_cycles;

    polynomial_false_position_root dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .left_end        (left_end),
        .right_end       (right_end),
        .done            (done),
        .root            (root),
        .outcome         (outcome),
        .iteration_count (iteration_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // trunc0(acc * x / 2^16) with saturation
    function automatic logic signed [63:0] q16_mul_sat(input logic signed [63:0] acc,
                                                       input logic signed [31:0] x);
        logic        neg;
        logic [63:0] ua, ub, h, l, q;
        neg = acc[63] != x[31];
        ua = acc[63] ? 64'(-acc) : 64'(acc);
        ub = x[31] ? -(64'(x)) : 64'(x);
        h = (ua >> 32) * ub;
        l = (ua & 64'hFFFF_FFFF) * ub;
        if (h >= 64'h0000_8000_0000_0000)
            q = 64'h7FFF_FFFF_FFFF_FFFF;
        else
        begin
            q = (h << 16) + (l >> 16);
            if (q > 64'h7FFF_FFFF_FFFF_FFFF)
                q = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return neg ? -q : q;
    endfunction

    // saturating 64-bit add
    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF)
            return -64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // horner evaluation with the eps rule
    function automatic logic signed [63:0] poly_at(input logic signed [31:0] x);
        logic signed [63:0] acc;
        acc = 0;
        for (int i = 0; i < int'(poly_len); i++)
            acc = add_sat(q16_mul_sat(acc, x), 64'(poly_coef[i]));
        if (abs64(acc) < 7)
            acc = 0;
        return acc;
    endfunction

    // intercept of the chord through (a, fa) and (b, fb)
    function automatic logic signed [63:0] chord_x(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic signed [63:0] fa,
                                                   input logic signed [63:0] fb);
        logic [63:0]        ma, mb, r, d;
        logic signed [63:0] span;
        ma = abs64(fa);
        mb = abs64(fb);
        span = b - a;
        while (ma + mb >= 64'h1_0000_0000)
        begin
            ma = ma >> 1;
            mb = mb >> 1;
        end
        if (ma + mb == 0)
            return a;
        r = (ma << 31) / (ma + mb);
        d = (abs64(span) * r) >> 31;
        return span[63] ? a - d : a + d;
    endfunction

    // expected result of one search
    function automatic root_result_t find_root(input logic signed [31:0] lo_x,
                                               input logic signed [31:0] hi_x);
        logic signed [63:0] a, b, fa, fb, x, fx;
        logic [1:0]         res_code;
        int                 chords;
        root_result_t       r;
        a = 64'(lo_x);
        b = 64'(hi_x);
        fa = poly_at(lo_x);
        fb = poly_at(hi_x);
        x = a;
        res_code = OUT_LIMIT;
        chords = 0;
        if ((fa >= 0 && fb >= 0) || (fa <= 0 && fb <= 0))
        begin
            if (fa == 0)
                res_code = OUT_ENDPOINT;
            else if (fb == 0)
            begin
                x = b;
                res_code = OUT_ENDPOINT;
            end
            else
            begin
                x = 0;
                res_code = OUT_NO_BRACKET;
            end
        end
        else
        begin
            while (abs64(a - b) >= 7 && chords < MAX_ITERATIONS)
            begin
                x = chord_x(a, b, fa, fb);
                if (abs64(x) < 7)
                    x = 0;
                fx = poly_at(x[31:0]);
                if (fx == 0)
                begin
                    res_code = OUT_CONVERGED;
                    break;
                end
                if ((fa < 0) != (fx < 0))
                begin
                    b = x;
                    fb = fx;
                end
                else
                begin
                    a = x;
                    fa = fx;
                end
                chords++;
            end
        end
        r.root = x[31:0];
        r.outcome = res_code;
        r.iters = chords[ITER_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // record the expected result of each accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_roots.push_back(find_root(left_end, right_end));
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        root_result_t want;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
                report_mismatch("unexpected result", root, 0);
            else
            begin
                want = pending_roots.pop_front();
                if (root !== want.root)
                    report_mismatch("root", root, want.root);
                if (outcome !== want.outcome)
                    report_mismatch("outcome", 32'(outcome), 32'(want.outcome));
                if (iteration_count !== want.iters)
                    report_mismatch("iteration_count", 32'(iteration_count),
                                    32'(want.iters));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_write || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_COUNT)
            poly_len = value[2:0];
        else
            poly_coef[idx - CFG_COEF0] = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // load count and all seven coefficient registers
    task automatic load_poly(input logic [2:0] len, input logic signed [31:0] c [7]);
        write_reg(CFG_COUNT, 32'(len));
        for (int i = 0; i < MAX_COEFFS; i++)
            write_reg(CFG_COEF0 + 3'(i), c[i]);
    endtask

    task automatic drain;
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one search transfer, then an optional gap
    task automatic send_interval(input logic signed [31:0] a, input logic signed [31:0] b,
                                 input int gap);
        @(negedge clk);
        start     <= 1'b1;
        left_end  <= a;
        right_end <= b;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    task automatic test_reset_values;
        send_interval(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_interval(32'sh8000_0000, 0, 2);
        drain();
    endtask

    task automatic test_zero_count;
        write_reg(CFG_COUNT, 0);
        send_interval(32'sh0001_0000, -32'sh0003_0000, 0);
        drain();
    endtask

    task automatic test_no_bracket;
        logic signed [31:0] c [7];
        c = '{32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 0, 0};
        load_poly(3, c);
        send_interval(-32'sh0002_0000, 32'sh0002_0000, 0);
        drain();
    endtask

    task automatic test_convergence;
        logic signed [31:0] c [7];
        c = '{32'sh0001_0000, 0, -32'sh0002_0000, 0, 0, 0, 0};
        load_poly(3, c);
        send_interval(0, 32'sh0002_0000, 0);
        send_interval(-32'sh0002_0000, 0, 1);
        send_interval(32'sh0002_0000, -32'sh0000_8000, 0);
        drain();
    endtask

    task automatic test_endpoint_roots;
        logic signed [31:0] c [7];
        c = '{32'sh0001_0000, -32'sh0001_0000, 0, 0, 0, 0, 0};
        load_poly(2, c);
        send_interval(0, 32'sh0001_0000, 0);
        send_interval(32'sh0001_0000, 32'sh0005_0000, 0);
        drain();
        // both ends roots: quadratic x^2 - 1 at -1 and 1
        c = '{32'sh0001_0000, 0, -32'sh0001_0000, 0, 0, 0, 0};
        load_poly(3, c);
        send_interval(-32'sh0001_0000, 32'sh0001_0000, 0);
        drain();
    endtask

    task automatic test_short_interval;
        logic signed [31:0] c [7];
        // steep line: ends 3 and 103 lsb apart still bracket the root
        c = '{32'sh7FFF_0000, 0, 0, 0, 0, 0, 0};
        load_poly(2, c);
        send_interval(-1, 2, 0);
        send_interval(-32'sd100, 32'sd3, 0);
        drain();
    endtask

    task automatic test_saturation;
        logic signed [31:0] c [7];
        c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        load_poly(7, c);
        send_interval(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_interval(-32'sh0000_0001, 32'sh0000_0001, 0);
        drain();
        // cube with root far from both ends: slow, may hit the chord limit
        c = '{32'sh0001_0000, 0, 0, -32'sh0000_0100, 0, 0, 0};
        load_poly(4, c);
        send_interval(-32'sh0100_0000, 32'sh7FFF_FFFF, 0);
        drain();
    endtask

    function automatic logic signed [31:0] pick_end(input bit narrow);
        if (narrow)
            return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        return $urandom;
    endfunction

    task automatic test_random_polys;
        logic signed [31:0] c [7];
        logic signed [31:0] a, b;
        int                 burst;
        bit                 narrow_poly;
        for (int phase = 0; phase < 10; phase++)
        begin
            narrow_poly = (phase % 4) != 3;
            for (int i = 0; i < MAX_COEFFS; i++)
                c[i] = narrow_poly ? $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000
                                   : $signed($urandom);
            load_poly(phase == 0 ? 3'd7 : 3'($urandom_range(1, 7)), c);
            burst = 0;
            for (int n = 0; n < 10; n++)
            begin
                a = pick_end($urandom_range(0, 4) != 0);
                b = pick_end($urandom_range(0, 4) != 0);
                if (burst == 0)
                    burst = $urandom_range(1, 5);
                burst--;
                send_interval(a, b, burst == 0 ? $urandom_range(0, 30) : 0);
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        left_end  = '0;
        right_end = '0;
        mismatches  = 0;
        idle_cycles = 0;
        poly_len = 3'd1;
        for (int i = 0; i < MAX_COEFFS; i++)
            poly_coef[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_zero_count();
        test_no_bracket();
        test_convergence();
        test_endpoint_roots();
        test_short_interval();
        test_saturation();
        test_random_polys();

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
